// ===== rtl/core/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
package ple_pkg;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_DELETE = 3'd2,
    FN_WRITE  = 3'd3,
    FN_READ   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_FULL  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT,
    ST_MOVE,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_IDX
  } waddr_sel_e;

  typedef enum logic [1:0] {
    RA_POS,
    RA_PREV,
    RA_NEXT
  } raddr_sel_e;

  typedef enum logic {
    WD_VAL,
    WD_RAM
  } wdata_sel_e;

  typedef struct packed {
    logic       latch_req;
    logic       save_err;
    logic       ram_we;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    logic       ram_re;
    raddr_sel_e raddr_sel;
    logic       idx_load_count;
    logic       idx_load_pos;
    logic       idx_inc;
    logic       idx_dec;
    logic       cnt_inc;
    logic       cnt_dec;
  } cmd_t;

  typedef struct packed {
    func_e func;
    err_e  err;
    logic  shift_done;
  } status_t;

  localparam int unsigned WordW = 32;
  localparam int unsigned FuncW = 3;
  localparam int unsigned PosW  = 6;
  localparam int unsigned LenW  = 7;
  localparam int unsigned ErrW  = 2;

endpackage

// ===== rtl/core/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// Sequencing state machine for the positional list engine.
module ple_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  ple_pkg::status_t sts_i,
  output ple_pkg::cmd_t    cmd_o
);

  ple_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.waddr_sel = ple_pkg::WA_IDX;
    cmd_o.wdata_sel = ple_pkg::WD_VAL;
    cmd_o.raddr_sel = ple_pkg::RA_POS;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ple_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.latch_req = 1'b1;
          state_d = ple_pkg::ST_DECIDE;
        end
      end
      ple_pkg::ST_DECIDE: begin
        cmd_o.save_err = 1'b1;
        state_d = ple_pkg::ST_RESP;
        if (sts_i.err == ple_pkg::ERR_OK) begin
          case (sts_i.func)
            ple_pkg::FN_APPEND: begin
              cmd_o.ram_we    = 1'b1;
              cmd_o.waddr_sel = ple_pkg::WA_COUNT;
              cmd_o.cnt_inc   = 1'b1;
            end
            ple_pkg::FN_WRITE: begin
              cmd_o.ram_we    = 1'b1;
              cmd_o.waddr_sel = ple_pkg::WA_POS;
            end
            ple_pkg::FN_READ: begin
              cmd_o.ram_re    = 1'b1;
              cmd_o.raddr_sel = ple_pkg::RA_POS;
            end
            ple_pkg::FN_INSERT: begin
              cmd_o.idx_load_count = 1'b1;
              state_d = ple_pkg::ST_SHIFT;
            end
            ple_pkg::FN_DELETE: begin
              cmd_o.idx_load_pos = 1'b1;
              state_d = ple_pkg::ST_SHIFT;
            end
            default: begin
              state_d = ple_pkg::ST_RESP;
            end
          endcase
        end
      end
      ple_pkg::ST_SHIFT: begin
        if (sts_i.shift_done) begin
          if (sts_i.func == ple_pkg::FN_INSERT) begin
            cmd_o.ram_we    = 1'b1;
            cmd_o.waddr_sel = ple_pkg::WA_IDX;
            cmd_o.wdata_sel = ple_pkg::WD_VAL;
            cmd_o.cnt_inc   = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = ple_pkg::ST_RESP;
        end else begin
          cmd_o.ram_re    = 1'b1;
          cmd_o.raddr_sel = (sts_i.func == ple_pkg::FN_INSERT) ? ple_pkg::RA_PREV
                                                                : ple_pkg::RA_NEXT;
          state_d = ple_pkg::ST_MOVE;
        end
      end
      ple_pkg::ST_MOVE: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.waddr_sel = ple_pkg::WA_IDX;
        cmd_o.wdata_sel = ple_pkg::WD_RAM;
        if (sts_i.func == ple_pkg::FN_INSERT) begin
          cmd_o.idx_dec = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
        state_d = ple_pkg::ST_SHIFT;
      end
      ple_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = ple_pkg::ST_IDLE;
      end
      default: begin
        state_d = ple_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ple_dp.sv =====
// Request registers, element count, shift index and element store.
module ple_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ple_pkg::FuncW-1:0]       func_i,
  input  logic [ple_pkg::PosW-1:0]        position_i,
  input  logic [ple_pkg::WordW-1:0]       value_i,
  input  ple_pkg::cmd_t                   cmd_i,
  output ple_pkg::status_t                sts_o,
  output logic [ple_pkg::WordW-1:0]       read_value_o,
  output logic [ple_pkg::LenW-1:0]        list_length_o,
  output logic [ple_pkg::ErrW-1:0]        error_code_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [ple_pkg::FuncW-1:0] func_q;
  logic [ple_pkg::PosW-1:0]  pos_q;
  logic [ple_pkg::WordW-1:0] val_q;
  logic [CW-1:0]             count_q;
  logic [AW-1:0]             idx_q;
  ple_pkg::err_e             err_q;
  logic                      rsel_q;

  ple_pkg::func_e            func;
  ple_pkg::err_e             err;
  logic                      is_empty, is_range, is_full;
  logic [AW-1:0]             waddr, raddr;
  logic [ple_pkg::WordW-1:0] wdata, rdata;

  assign func     = ple_pkg::func_e'(func_q);
  assign is_empty = (count_q == '0);
  assign is_range = (32'(pos_q) >= 32'(count_q));
  assign is_full  = (32'(count_q) >= 32'(DEPTH));

  always_comb begin
    case (func)
      ple_pkg::FN_APPEND: err = is_full ? ple_pkg::ERR_FULL : ple_pkg::ERR_OK;
      ple_pkg::FN_INSERT: begin
        if (is_empty)      err = ple_pkg::ERR_EMPTY;
        else if (is_range) err = ple_pkg::ERR_RANGE;
        else if (is_full)  err = ple_pkg::ERR_FULL;
        else               err = ple_pkg::ERR_OK;
      end
      ple_pkg::FN_DELETE, ple_pkg::FN_WRITE, ple_pkg::FN_READ: begin
        if (is_empty)      err = ple_pkg::ERR_EMPTY;
        else if (is_range) err = ple_pkg::ERR_RANGE;
        else               err = ple_pkg::ERR_OK;
      end
      default: err = ple_pkg::ERR_OK;
    endcase
  end

  assign sts_o.func = func;
  assign sts_o.err  = err;
  assign sts_o.shift_done = (func == ple_pkg::FN_INSERT)
                          ? (32'(idx_q) == 32'(pos_q))
                          : (32'(idx_q) + 32'd1 >= 32'(count_q));

  always_comb begin
    unique case (cmd_i.waddr_sel)
      ple_pkg::WA_COUNT: waddr = AW'(count_q);
      ple_pkg::WA_POS:   waddr = AW'(pos_q);
      default:           waddr = idx_q;
    endcase
    unique case (cmd_i.raddr_sel)
      ple_pkg::RA_PREV: raddr = AW'(idx_q - AW'(1));
      ple_pkg::RA_NEXT: raddr = AW'(idx_q + AW'(1));
      default:          raddr = AW'(pos_q);
    endcase
    wdata = (cmd_i.wdata_sel == ple_pkg::WD_RAM) ? rdata : val_q;
  end

  ple_ram #(
    .WIDTH(ple_pkg::WordW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      func_q <= func_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (cmd_i.idx_load_count) begin
      idx_q <= AW'(count_q);
    end else if (cmd_i.idx_load_pos) begin
      idx_q <= AW'(pos_q);
    end else if (cmd_i.idx_inc) begin
      idx_q <= AW'(idx_q + AW'(1));
    end else if (cmd_i.idx_dec) begin
      idx_q <= AW'(idx_q - AW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= ple_pkg::ERR_OK;
      rsel_q  <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= CW'(count_q + CW'(1));
      end else if (cmd_i.cnt_dec) begin
        count_q <= CW'(count_q - CW'(1));
      end
      if (cmd_i.save_err) begin
        err_q  <= err;
        rsel_q <= (func == ple_pkg::FN_READ) && (err == ple_pkg::ERR_OK);
      end
    end
  end

  assign read_value_o  = rsel_q ? rdata : '0;
  assign list_length_o = ple_pkg::LenW'(count_q);
  assign error_code_o  = err_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("element count above depth");
  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.save_err && err != ple_pkg::ERR_OK) |=> $stable(count_q))
    else $error("flagged request changed the count");
`endif

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level: bounded ordered list of 32-bit words with positional edits.
// Append, overwrite, read and flagged requests pass from accept through ST_DECIDE to the
// done_o strobe in ST_RESP. Insert and delete pass through ST_SHIFT and ST_MOVE once per
// moved entry, with one read and one write of the single-read, single-write element store
// each; a new request is taken the cycle after the strobe. The receiver cannot stall. Reset
// empties the list; the element store is not cleared and needs no clearing pass.
module positional_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ple_pkg::FuncW-1:0] func_i,
  input  logic [ple_pkg::PosW-1:0]  position_i,
  input  logic [ple_pkg::WordW-1:0] value_i,
  output logic                      done_o,
  output logic [ple_pkg::WordW-1:0] read_value_o,
  output logic [ple_pkg::LenW-1:0]  list_length_o,
  output logic [ple_pkg::ErrW-1:0]  error_code_o
);

  ple_pkg::cmd_t    cmd;
  ple_pkg::status_t sts;

  ple_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ple_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_value_o (read_value_o),
    .list_length_o(list_length_o),
    .error_code_o (error_code_o)
  );

`ifndef SYNTH
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request accepted without going busy");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");
`endif

endmodule

// ===== test/positional_list_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine: directed table, then biased random requests.
module positional_list_engine_test;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic [ple_pkg::FuncW-1:0] FN_UNUSED5 = 3'd5;
  localparam logic [ple_pkg::FuncW-1:0] FN_UNUSED6 = 3'd6;
  localparam logic [ple_pkg::FuncW-1:0] FN_UNUSED7 = 3'd7;

  typedef struct {
    logic [ple_pkg::WordW-1:0] rd;
    logic [ple_pkg::LenW-1:0]  len;
    ple_pkg::err_e             err;
  } list_result_t;

  typedef struct {
    logic [ple_pkg::FuncW-1:0] fn;
    logic [ple_pkg::PosW-1:0]  pos;
    logic [ple_pkg::WordW-1:0] val;
    bit                        typed;
    list_result_t              res;
  } list_request_t;

  typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED} drift_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [ple_pkg::FuncW-1:0] func_i;
  logic [ple_pkg::PosW-1:0] position_i;
  logic [ple_pkg::WordW-1:0] value_i;
  logic done_o;
  logic [ple_pkg::WordW-1:0] read_value_o;
  logic [ple_pkg::LenW-1:0] list_length_o;
  logic [ple_pkg::ErrW-1:0] error_code_o;

  logic [ple_pkg::WordW-1:0] list_words [DEPTH];
  int unsigned list_len;
  list_result_t expected_results [$];
  list_request_t directed_rows [$];
  int unsigned failures;
  int unsigned idle_pct;
  int unsigned stall_cycles;

  positional_list_engine #(.DEPTH(DEPTH)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .list_length_o(list_length_o),
    .error_code_o (error_code_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic ple_pkg::err_e position_status(logic [ple_pkg::PosW-1:0] pos);
    if (list_len == 0) return ple_pkg::ERR_EMPTY;
    if (pos >= list_len) return ple_pkg::ERR_RANGE;
    return ple_pkg::ERR_OK;
  endfunction

  function automatic list_result_t apply_request(logic [ple_pkg::FuncW-1:0] fn,
                                                 logic [ple_pkg::PosW-1:0] pos,
                                                 logic [ple_pkg::WordW-1:0] val);
    list_result_t res;
    int unsigned i;
    res.rd = '0;
    res.err = ple_pkg::ERR_OK;
    case (fn)
      ple_pkg::FN_APPEND: begin
        if (list_len >= DEPTH) begin
          res.err = ple_pkg::ERR_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      ple_pkg::FN_INSERT: begin
        res.err = position_status(pos);
        if (res.err == ple_pkg::ERR_OK && list_len >= DEPTH) res.err = ple_pkg::ERR_FULL;
        if (res.err == ple_pkg::ERR_OK) begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      ple_pkg::FN_DELETE: begin
        res.err = position_status(pos);
        if (res.err == ple_pkg::ERR_OK) begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ple_pkg::FN_WRITE: begin
        res.err = position_status(pos);
        if (res.err == ple_pkg::ERR_OK) list_words[pos] = val;
      end
      ple_pkg::FN_READ: begin
        res.err = position_status(pos);
        if (res.err == ple_pkg::ERR_OK) res.rd = list_words[pos];
      end
      default: begin
      end
    endcase
    res.len = ple_pkg::LenW'(list_len);
    return res;
  endfunction

  function automatic void add_row(logic [ple_pkg::FuncW-1:0] fn, logic [ple_pkg::PosW-1:0] pos,
                                  logic [ple_pkg::WordW-1:0] val, bit typed,
                                  logic [ple_pkg::WordW-1:0] rd,
                                  logic [ple_pkg::LenW-1:0] len, ple_pkg::err_e err);
    list_request_t row;
    row.fn = fn;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.res.rd = rd;
    row.res.len = len;
    row.res.err = err;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [ple_pkg::FuncW-1:0] pick_func(drift_e drift);
    int unsigned r;
    r = $urandom_range(99);
    case (drift)
      DRIFT_GROW: begin
        if (r < 45) return ple_pkg::FN_APPEND;
        if (r < 75) return ple_pkg::FN_INSERT;
        if (r < 83) return ple_pkg::FN_READ;
        if (r < 90) return ple_pkg::FN_WRITE;
        if (r < 96) return ple_pkg::FN_DELETE;
      end
      DRIFT_SHRINK: begin
        if (r < 55) return ple_pkg::FN_DELETE;
        if (r < 65) return ple_pkg::FN_APPEND;
        if (r < 70) return ple_pkg::FN_INSERT;
        if (r < 82) return ple_pkg::FN_READ;
        if (r < 95) return ple_pkg::FN_WRITE;
      end
      default: begin
        if (r < 19) return ple_pkg::FN_APPEND;
        if (r < 38) return ple_pkg::FN_INSERT;
        if (r < 57) return ple_pkg::FN_DELETE;
        if (r < 76) return ple_pkg::FN_WRITE;
        if (r < 96) return ple_pkg::FN_READ;
      end
    endcase
    case ($urandom_range(2))
      0: return FN_UNUSED5;
      1: return FN_UNUSED6;
      default: return FN_UNUSED7;
    endcase
  endfunction

  function automatic list_request_t random_request(drift_e drift);
    list_request_t row;
    int unsigned r;
    row.fn = pick_func(drift);
    r = $urandom_range(9);
    if (list_len > 0 && r < 8) row.pos = ple_pkg::PosW'($urandom_range(list_len - 1));
    else if (r == 8) row.pos = ple_pkg::PosW'(list_len);
    else row.pos = ple_pkg::PosW'($urandom);
    case ($urandom_range(9))
      0: row.val = '0;
      1: row.val = '1;
      default: row.val = $urandom;
    endcase
    row.typed = 1'b0;
    row.res.rd = '0;
    row.res.len = '0;
    row.res.err = ple_pkg::ERR_OK;
    return row;
  endfunction

  // Hold the request until accepted, then record what it must return.
  task automatic issue(list_request_t row);
    list_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= row.fn;
    position_i <= row.pos;
    value_i <= row.val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_request(row.fn, row.pos, row.val);
    expected_results.push_back(row.typed ? row.res : predicted);
  endtask

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: read_value %h list_length %0d error_code %0d",
               read_value_o, list_length_o, error_code_o);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (read_value_o !== exp_res.rd) begin
          $error("read_value expected %h actual %h", exp_res.rd, read_value_o);
          failures++;
        end
        if (list_length_o !== exp_res.len) begin
          $error("list_length expected %0d actual %0d", exp_res.len, list_length_o);
          failures++;
        end
        if (error_code_o !== exp_res.err) begin
          $error("error_code expected %0d actual %0d", exp_res.err, error_code_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    drift_e drift;
    int unsigned sent;
    int unsigned run;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = '0;
    position_i = '0;
    value_i = '0;
    failures = 0;
    idle_pct = 9;
    stall_cycles = 0;
    list_len = 0;

    add_row(ple_pkg::FN_READ,   6'd0,  32'h0,        1'b1, 32'h0, 7'd0, ple_pkg::ERR_EMPTY);
    add_row(ple_pkg::FN_DELETE, 6'd63, 32'h0,        1'b1, 32'h0, 7'd0, ple_pkg::ERR_EMPTY);
    add_row(ple_pkg::FN_INSERT, 6'd0,  32'hFFFFFFFF, 1'b1, 32'h0, 7'd0, ple_pkg::ERR_EMPTY);
    add_row(ple_pkg::FN_WRITE,  6'd5,  32'h12345678, 1'b1, 32'h0, 7'd0, ple_pkg::ERR_EMPTY);
    add_row(FN_UNUSED5,         6'd0,  32'hFFFFFFFF, 1'b1, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_APPEND, 6'd63, 32'hFFFFFFFF, 1'b1, 32'h0, 7'd1, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_APPEND, 6'd0,  32'h00000000, 1'b1, 32'h0, 7'd2, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd0,  32'h0,        1'b1, 32'hFFFFFFFF, 7'd2, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd1,  32'hFFFFFFFF, 1'b1, 32'h0, 7'd2, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd2,  32'h0,        1'b1, 32'h0, 7'd2, ple_pkg::ERR_RANGE);
    add_row(ple_pkg::FN_WRITE,  6'd63, 32'hFFFFFFFF, 1'b1, 32'h0, 7'd2, ple_pkg::ERR_RANGE);
    add_row(ple_pkg::FN_INSERT, 6'd0,  32'h3F800000, 1'b1, 32'h0, 7'd3, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_INSERT, 6'd2,  32'h80000000, 1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_WRITE,  6'd1,  32'h7FC00000, 1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd1,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_DELETE, 6'd3,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_DELETE, 6'd0,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(FN_UNUSED7,         6'd63, 32'hFFFFFFFF, 1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd0,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_READ,   6'd1,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_DELETE, 6'd1,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_DELETE, 6'd0,  32'h0,        1'b0, 32'h0, 7'd0, ple_pkg::ERR_OK);
    add_row(ple_pkg::FN_DELETE, 6'd0,  32'h0,        1'b1, 32'h0, 7'd0, ple_pkg::ERR_EMPTY);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) issue(directed_rows[i]);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 9 : (phase == 1) ? 63 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        drift = drift_e'($urandom_range(2));
        run = $urandom_range(20, 120);
        repeat (run) begin
          issue(random_request(drift));
          sent++;
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
